[hw/rtl/sxtok_pkg.sv]
// Shared types and character constants for the S-expression token scanner.
`timescale 1ns / 1ps

package sxtok_pkg;

	localparam int NUMBER_W = 32;
	localparam int POS_OUT_W = 16;
	localparam int RESULT_SLOTS = 3;

	typedef enum logic [2:0] {
		KIND_LPAREN = 3'd0,
		KIND_RPAREN = 3'd1,
		KIND_INT    = 3'd2,
		KIND_SYM    = 3'd3,
		KIND_END    = 3'd4,
		KIND_ERR    = 3'd5
	} kind_t;

	typedef enum logic [1:0] {
		MODE_IDLE = 2'd0,
		MODE_INT  = 2'd1,
		MODE_SYM  = 2'd2,
		MODE_ERR  = 2'd3
	} mode_t;

	typedef struct packed {
		kind_t                 kind;
		logic [NUMBER_W-1:0]   number;
		logic [POS_OUT_W-1:0]  start_offset;
		logic [POS_OUT_W-1:0]  token_length;
		logic [POS_OUT_W-1:0]  line_no;
		logic [POS_OUT_W-1:0]  column_no;
	} result_t;

	localparam logic [7:0] CHAR_TAB    = 8'h09;
	localparam logic [7:0] CHAR_NL     = 8'h0A;
	localparam logic [7:0] CHAR_CR     = 8'h0D;
	localparam logic [7:0] CHAR_SPACE  = 8'h20;
	localparam logic [7:0] CHAR_LPAREN = 8'h28;
	localparam logic [7:0] CHAR_RPAREN = 8'h29;
	localparam logic [7:0] CHAR_STAR   = 8'h2A;
	localparam logic [7:0] CHAR_PLUS   = 8'h2B;
	localparam logic [7:0] CHAR_MINUS  = 8'h2D;
	localparam logic [7:0] CHAR_SLASH  = 8'h2F;
	localparam logic [7:0] CHAR_ZERO   = 8'h30;
	localparam logic [7:0] CHAR_NINE   = 8'h39;
	localparam logic [7:0] CHAR_UP_A   = 8'h41;
	localparam logic [7:0] CHAR_UP_Z   = 8'h5A;
	localparam logic [7:0] CHAR_UNDER  = 8'h5F;
	localparam logic [7:0] CHAR_LO_A   = 8'h61;
	localparam logic [7:0] CHAR_LO_Z   = 8'h7A;

endpackage

[hw/rtl/sxtok_if.sv]
// Valid/ready channel interfaces for source bytes and scanner tokens.
`timescale 1ns / 1ps

interface sxtok_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] char_in;
	logic       final_byte;

	modport source (output valid, output char_in, output final_byte, input ready);
	modport sink (input valid, input char_in, input final_byte, output ready);
endinterface

interface sxtok_out_if import sxtok_pkg::*;;
	logic                 valid;
	logic                 ready;
	logic [2:0]           kind;
	logic [NUMBER_W-1:0]  number;
	logic [POS_OUT_W-1:0] start_offset;
	logic [POS_OUT_W-1:0] token_length;
	logic [POS_OUT_W-1:0] line_no;
	logic [POS_OUT_W-1:0] column_no;
	logic                 run_end;

	modport source (output valid, output kind, output number, output start_offset,
		output token_length, output line_no, output column_no, output run_end,
		input ready);
	modport sink (input valid, input kind, input number, input start_offset,
		input token_length, input line_no, input column_no, input run_end,
		output ready);
endinterface

[hw/rtl/sxtok_scan.sv]
// Scanner state and per-byte token classification, producing up to three results.
`timescale 1ns / 1ps

module sxtok_scan import sxtok_pkg::*; #(
	parameter int POSITION_BITS = 16,
	parameter int VALUE_BITS    = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        take,
	input  logic [7:0]  char_in,
	input  logic        final_byte,
	output result_t     res [RESULT_SLOTS],
	output logic [RESULT_SLOTS-1:0] res_mask
);

	typedef logic [POSITION_BITS-1:0] pos_t;
	typedef logic [VALUE_BITS-1:0]    val_t;

	mode_t mode_q, mode_n;
	pos_t  cur_line_q, cur_col_q, cur_off_q, tok_start_q, tok_line_q, tok_col_q;
	pos_t  cur_line_n, cur_col_n, cur_off_n, tok_start_n, tok_line_n, tok_col_n;
	val_t  accum_q, accum_n, accum_x10;

	logic       is_dig, is_letter, is_extra, is_space, sym_cont;
	logic       finish0, used, b_valid, f_valid, end_valid;
	kind_t      b_kind;
	logic [3:0] dval;

	function automatic pos_t sat_inc(input pos_t v);
		return (v == '1) ? v : v + 1'b1;
	endfunction

	function automatic logic [POS_OUT_W-1:0] clip_pos(input pos_t v);
		return (32'(v) > 32'h0000_FFFF) ? 16'hFFFF : POS_OUT_W'(v);
	endfunction

	function automatic pos_t span(input pos_t stop, input pos_t start);
		return (stop >= start) ? stop - start : '0;
	endfunction

	function automatic logic [NUMBER_W-1:0] num_out(input val_t a);
		return NUMBER_W'(64'(a));
	endfunction

	always_comb begin
		is_dig    = (char_in >= CHAR_ZERO) && (char_in <= CHAR_NINE);
		is_letter = ((char_in >= CHAR_UP_A) && (char_in <= CHAR_UP_Z)) ||
			((char_in >= CHAR_LO_A) && (char_in <= CHAR_LO_Z));
		is_extra  = (char_in == CHAR_UNDER) || (char_in == CHAR_PLUS) ||
			(char_in == CHAR_MINUS) || (char_in == CHAR_STAR) || (char_in == CHAR_SLASH);
		is_space  = (char_in == CHAR_SPACE) || ((char_in >= CHAR_TAB) && (char_in <= CHAR_CR));
		sym_cont  = is_letter || is_dig || is_extra;
		dval      = 4'(char_in - CHAR_ZERO);
		accum_x10 = {accum_q[VALUE_BITS-4:0], 3'b000} + {accum_q[VALUE_BITS-2:0], 1'b0} +
			VALUE_BITS'(dval);

		used    = ((mode_q == MODE_INT) && is_dig) || ((mode_q == MODE_SYM) && sym_cont);
		finish0 = ((mode_q == MODE_INT) && !is_dig) || ((mode_q == MODE_SYM) && !sym_cont);

		mode_n      = finish0 ? MODE_IDLE : mode_q;
		tok_start_n = tok_start_q;
		tok_line_n  = tok_line_q;
		tok_col_n   = tok_col_q;
		accum_n     = ((mode_q == MODE_INT) && is_dig) ? accum_x10 : accum_q;
		b_valid     = 1'b0;
		b_kind      = KIND_ERR;

		if (!used) begin
			if (is_space) begin
				b_valid = 1'b0;
			end else if (char_in == CHAR_LPAREN) begin
				b_valid = 1'b1;
				b_kind  = KIND_LPAREN;
			end else if (char_in == CHAR_RPAREN) begin
				b_valid = 1'b1;
				b_kind  = KIND_RPAREN;
			end else if (is_dig || is_letter || is_extra) begin
				mode_n      = is_dig ? MODE_INT : MODE_SYM;
				tok_start_n = cur_off_q;
				tok_line_n  = cur_line_q;
				tok_col_n   = cur_col_q;
				if (is_dig) begin
					accum_n = VALUE_BITS'(dval);
				end
			end else begin
				b_valid = 1'b1;
				b_kind  = KIND_ERR;
				mode_n  = MODE_ERR;
			end
		end

		cur_line_n = (char_in == CHAR_NL) ? sat_inc(cur_line_q) : cur_line_q;
		cur_col_n  = (char_in == CHAR_NL) ? pos_t'(1) : sat_inc(cur_col_q);
		cur_off_n  = sat_inc(cur_off_q);

		f_valid   = final_byte && ((mode_n == MODE_INT) || (mode_n == MODE_SYM));
		end_valid = final_byte && (mode_n != MODE_ERR);

		res[0].kind         = (mode_q == MODE_INT) ? KIND_INT : KIND_SYM;
		res[0].number       = (mode_q == MODE_INT) ? num_out(accum_q) : '0;
		res[0].start_offset = clip_pos(tok_start_q);
		res[0].token_length = clip_pos(span(cur_off_q, tok_start_q));
		res[0].line_no      = clip_pos(tok_line_q);
		res[0].column_no    = clip_pos(tok_col_q);

		if (b_valid) begin
			res[1].kind         = b_kind;
			res[1].number       = (b_kind == KIND_ERR) ? NUMBER_W'(char_in) : '0;
			res[1].start_offset = clip_pos(cur_off_q);
			res[1].token_length = POS_OUT_W'(1);
			res[1].line_no      = clip_pos(cur_line_q);
			res[1].column_no    = clip_pos(cur_col_q);
		end else begin
			res[1].kind         = (mode_n == MODE_INT) ? KIND_INT : KIND_SYM;
			res[1].number       = (mode_n == MODE_INT) ? num_out(accum_n) : '0;
			res[1].start_offset = clip_pos(tok_start_n);
			res[1].token_length = clip_pos(span(cur_off_n, tok_start_n));
			res[1].line_no      = clip_pos(tok_line_n);
			res[1].column_no    = clip_pos(tok_col_n);
		end

		res[2].kind         = KIND_END;
		res[2].number       = '0;
		res[2].start_offset = clip_pos(cur_off_n);
		res[2].token_length = '0;
		res[2].line_no      = clip_pos(cur_line_n);
		res[2].column_no    = clip_pos(cur_col_n);

		if (mode_q == MODE_ERR) begin
			res_mask = '0;
		end else begin
			res_mask = {end_valid, b_valid || f_valid, finish0};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= MODE_IDLE;
			cur_line_q  <= pos_t'(1);
			cur_col_q   <= pos_t'(1);
			cur_off_q   <= '0;
			tok_start_q <= '0;
			tok_line_q  <= pos_t'(1);
			tok_col_q   <= pos_t'(1);
			accum_q     <= '0;
		end else if (take) begin
			if (final_byte) begin
				mode_q      <= MODE_IDLE;
				cur_line_q  <= pos_t'(1);
				cur_col_q   <= pos_t'(1);
				cur_off_q   <= '0;
				tok_start_q <= '0;
				tok_line_q  <= pos_t'(1);
				tok_col_q   <= pos_t'(1);
				accum_q     <= '0;
			end else if (mode_q != MODE_ERR) begin
				mode_q      <= mode_n;
				cur_line_q  <= cur_line_n;
				cur_col_q   <= cur_col_n;
				cur_off_q   <= cur_off_n;
				tok_start_q <= tok_start_n;
				tok_line_q  <= tok_line_n;
				tok_col_q   <= tok_col_n;
				accum_q     <= accum_n;
			end
		end
	end

	// A source always ends with the scanner back between tokens at the origin.
	assert property (@(posedge clk) disable iff (!arst_n)
		take && final_byte |=> mode_q == MODE_IDLE && cur_off_q == '0)
		else $error("scanner did not restart after final byte");

	// A token start never lies beyond the current position.
	assert property (@(posedge clk) disable iff (!arst_n)
		tok_start_q <= cur_off_q)
		else $error("token start ahead of current offset");

	// After an unexpected byte the scanner ignores the source until its final byte.
	assert property (@(posedge clk) disable iff (!arst_n)
		mode_q == MODE_ERR && !(take && final_byte) |=> mode_q == MODE_ERR)
		else $error("scanner left error mode before the final byte");

endmodule

[hw/rtl/sexpr_token_scanner.sv]
// Top level of the S-expression token scanner with its result buffer.
//
//   channel   direction  payload
//   bytes     sink       char_in, final_byte
//   tokens    source     kind, number, start_offset, token_length, line_no, column_no, run_end
//
// A byte is scanned in the cycle of its transfer and its results (zero to three) appear
// in the result buffer in the cycle after, leaving one token per cycle unless tokens stall.
// A byte giving several results holds the byte channel until all but the last have drained;
// otherwise a byte transfers every cycle, including the cycle in which the last result transfers.
// Reset returns the scanner to the start of a source; there is no clearing pass.
// Stalls on the token side hold the buffer and, while it holds any token, the byte side.
`timescale 1ns / 1ps

module sexpr_token_scanner import sxtok_pkg::*; #(
	parameter int POSITION_BITS = 16,
	parameter int VALUE_BITS    = 32
) (
	input logic        clk,
	input logic        arst_n,
	sxtok_in_if.sink   bytes,
	sxtok_out_if.source tokens
);

	result_t                 scan_res [RESULT_SLOTS];
	logic [RESULT_SLOTS-1:0] scan_mask;
	result_t                 res_q [RESULT_SLOTS];
	logic [RESULT_SLOTS-1:0] mask_q, mask_pop;
	logic [1:0]              pick;
	logic                    take, fire;

	sxtok_scan #(
		.POSITION_BITS (POSITION_BITS),
		.VALUE_BITS    (VALUE_BITS)
	) u_scan (
		.clk        (clk),
		.arst_n     (arst_n),
		.take       (take),
		.char_in    (bytes.char_in),
		.final_byte (bytes.final_byte),
		.res        (scan_res),
		.res_mask   (scan_mask)
	);

	always_comb begin
		mask_pop = mask_q & (mask_q - 1'b1);
		if (mask_q[0]) begin
			pick = 2'd0;
		end else if (mask_q[1]) begin
			pick = 2'd1;
		end else begin
			pick = 2'd2;
		end
	end

	assign bytes.ready  = (mask_q == '0) || (tokens.ready && (mask_pop == '0));
	assign take         = bytes.valid && bytes.ready;
	assign fire         = tokens.valid && tokens.ready;

	assign tokens.valid        = |mask_q;
	assign tokens.kind         = res_q[pick].kind;
	assign tokens.number       = res_q[pick].number;
	assign tokens.start_offset = res_q[pick].start_offset;
	assign tokens.token_length = res_q[pick].token_length;
	assign tokens.line_no      = res_q[pick].line_no;
	assign tokens.column_no    = res_q[pick].column_no;
	assign tokens.run_end      = (mask_pop == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q <= '0;
		end else if (take) begin
			mask_q <= scan_mask;
		end else if (fire) begin
			mask_q <= mask_pop;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			res_q <= scan_res;
		end
	end

	// An empty buffer always takes the next byte.
	assert property (@(posedge clk) disable iff (!arst_n)
		mask_q == '0 |-> bytes.ready)
		else $error("byte channel stalled with an empty buffer");

	// Bytes wait while more than one token of the previous byte is pending.
	assert property (@(posedge clk) disable iff (!arst_n)
		$countones(mask_q) > 1 |-> !bytes.ready)
		else $error("byte taken while several tokens pending");

	// The end token is always the last result of its byte.
	assert property (@(posedge clk) disable iff (!arst_n)
		tokens.valid && tokens.kind == KIND_END |-> tokens.run_end)
		else $error("end token not marked as last result");

	// A transfer of the last pending token empties the buffer unless a byte was taken.
	assert property (@(posedge clk) disable iff (!arst_n)
		fire && tokens.run_end && !take |=> mask_q == '0)
		else $error("buffer not empty after last token transfer");

endmodule

[sim/sxtok_token_checker.sv]
// Token checker: predicts the scanner's tokens from transferred bytes and compares them.
`timescale 1ns / 1ps

module sxtok_token_checker import sxtok_pkg::*; (
	input logic   clk,
	input logic   arst_n,
	sxtok_in_if   byte_ch,
	sxtok_out_if  tok_ch,
	output int    mismatches,
	output int    outstanding
);

	typedef struct packed {
		result_t tok;
		logic    last;
	} token_exp_t;

	mode_t                scan_state;
	logic [POS_OUT_W-1:0] at_line, at_col, at_offset;
	logic [POS_OUT_W-1:0] tok_off, tok_ln, tok_cl;
	logic [NUMBER_W-1:0]  value_acc;

	result_t    step_out[$];
	token_exp_t predicted[$];
	token_exp_t want;
	int         fails;

	function automatic logic [POS_OUT_W-1:0] bump(logic [POS_OUT_W-1:0] v);
		return (v == '1) ? v : v + 1'b1;
	endfunction

	function automatic void restart();
		scan_state = MODE_IDLE;
		at_line = 1;
		at_col = 1;
		at_offset = 0;
		tok_off = 0;
		tok_ln = 1;
		tok_cl = 1;
		value_acc = 0;
	endfunction

	function automatic void emit(kind_t k, logic [NUMBER_W-1:0] num, logic [POS_OUT_W-1:0] st,
		logic [POS_OUT_W-1:0] len, logic [POS_OUT_W-1:0] ln, logic [POS_OUT_W-1:0] cl);
		result_t r;
		r.kind = k;
		r.number = num;
		r.start_offset = st;
		r.token_length = len;
		r.line_no = ln;
		r.column_no = cl;
		step_out.push_back(r);
	endfunction

	function automatic void close_token();
		if (scan_state == MODE_INT) begin
			emit(KIND_INT, value_acc, tok_off, at_offset - tok_off, tok_ln, tok_cl);
		end else if (scan_state == MODE_SYM) begin
			emit(KIND_SYM, '0, tok_off, at_offset - tok_off, tok_ln, tok_cl);
		end
		scan_state = MODE_IDLE;
	endfunction

	function automatic void open_token(mode_t m);
		scan_state = m;
		tok_off = at_offset;
		tok_ln = at_line;
		tok_cl = at_col;
	endfunction

	function automatic void scan_byte(logic [7:0] c, logic fin);
		logic taken, is_dig, is_word, is_blank;
		token_exp_t e;
		step_out.delete();
		taken = 1'b0;
		is_dig = c >= CHAR_ZERO && c <= CHAR_NINE;
		is_word = (c >= CHAR_UP_A && c <= CHAR_UP_Z) || (c >= CHAR_LO_A && c <= CHAR_LO_Z)
			|| c == CHAR_UNDER || c == CHAR_PLUS || c == CHAR_MINUS || c == CHAR_STAR
			|| c == CHAR_SLASH;
		is_blank = c == CHAR_SPACE || (c >= CHAR_TAB && c <= CHAR_CR);
		if (scan_state == MODE_ERR) begin
			if (fin) restart();
			return;
		end
		if (scan_state == MODE_INT && is_dig) begin
			value_acc = value_acc * 32'd10 + {24'd0, c - CHAR_ZERO};
			taken = 1'b1;
		end else if (scan_state == MODE_SYM && (is_dig || is_word)) begin
			taken = 1'b1;
		end else begin
			close_token();
		end
		if (!taken && !is_blank) begin
			if (c == CHAR_LPAREN) begin
				emit(KIND_LPAREN, '0, at_offset, 1, at_line, at_col);
			end else if (c == CHAR_RPAREN) begin
				emit(KIND_RPAREN, '0, at_offset, 1, at_line, at_col);
			end else if (is_dig) begin
				open_token(MODE_INT);
				value_acc = {24'd0, c - CHAR_ZERO};
			end else if (is_word) begin
				open_token(MODE_SYM);
			end else begin
				emit(KIND_ERR, {24'd0, c}, at_offset, 1, at_line, at_col);
				scan_state = MODE_ERR;
			end
		end
		if (c == CHAR_NL) begin
			at_line = bump(at_line);
			at_col = 1;
		end else begin
			at_col = bump(at_col);
		end
		at_offset = bump(at_offset);
		if (fin) begin
			if (scan_state != MODE_ERR) begin
				close_token();
				emit(KIND_END, '0, at_offset, 0, at_line, at_col);
			end
			restart();
		end
		foreach (step_out[i]) begin
			e.tok = step_out[i];
			e.last = (i == step_out.size() - 1);
			predicted.push_back(e);
		end
	endfunction

	function automatic void check_field(string name, logic [NUMBER_W-1:0] exp_v,
		logic [NUMBER_W-1:0] got_v);
		if (exp_v !== got_v) begin
			$error("%s: expected %0d, got %0d", name, exp_v, got_v);
			fails++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			restart();
			predicted.delete();
			fails = 0;
			mismatches <= 0;
			outstanding <= 0;
		end else begin
			if (byte_ch.valid && byte_ch.ready) begin
				scan_byte(byte_ch.char_in, byte_ch.final_byte);
			end
			if (tok_ch.valid && tok_ch.ready) begin
				if (predicted.size() == 0) begin
					$error("Token transfer with nothing predicted: kind %0d offset %0d",
						tok_ch.kind, tok_ch.start_offset);
					fails++;
				end else begin
					want = predicted.pop_front();
					check_field("kind", NUMBER_W'(want.tok.kind), NUMBER_W'(tok_ch.kind));
					check_field("number", want.tok.number, tok_ch.number);
					check_field("start_offset", NUMBER_W'(want.tok.start_offset),
						NUMBER_W'(tok_ch.start_offset));
					check_field("token_length", NUMBER_W'(want.tok.token_length),
						NUMBER_W'(tok_ch.token_length));
					check_field("line_no", NUMBER_W'(want.tok.line_no),
						NUMBER_W'(tok_ch.line_no));
					check_field("column_no", NUMBER_W'(want.tok.column_no),
						NUMBER_W'(tok_ch.column_no));
					check_field("run_end", NUMBER_W'(want.last), NUMBER_W'(tok_ch.run_end));
				end
			end
			mismatches <= fails;
			outstanding <= predicted.size();
		end
	end

endmodule

[sim/tb.sv]
// Testbench top: drives source bytes and token stalls into the scanner and gives the verdict.
`timescale 1ns / 1ps

module tb;
	import sxtok_pkg::*;

	localparam int LIMIT = 1_000_000;
	localparam logic [7:0] EXTRA [5] = '{CHAR_UNDER, CHAR_PLUS, CHAR_MINUS, CHAR_STAR, CHAR_SLASH};

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	bit   calm = 1'b0;
	int   cycles = 0;
	int   mismatches, outstanding;
	int   sent, ws, n;
	logic [7:0] src[$];

	sxtok_in_if  byte_ch ();
	sxtok_out_if tok_ch ();

	sexpr_token_scanner dut (
		.clk(clk),
		.arst_n(arst_n),
		.bytes(byte_ch),
		.tokens(tok_ch)
	);

	sxtok_token_checker token_check (
		.clk(clk),
		.arst_n(arst_n),
		.byte_ch(byte_ch),
		.tok_ch(tok_ch),
		.mismatches(mismatches),
		.outstanding(outstanding)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	task automatic send_byte(input logic [7:0] c, input logic fin);
		int gap;
		gap = calm ? 0 : $urandom_range(0, 8);
		if (gap > 0) begin
			byte_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		byte_ch.valid <= 1'b1;
		byte_ch.char_in <= c;
		byte_ch.final_byte <= fin;
		@(posedge clk);
		while (!byte_ch.ready) @(posedge clk);
	endtask

	task automatic send_text(input string s, input logic fin_last);
		for (int i = 0; i < s.len(); i++) begin
			send_byte(s[i], fin_last && i == s.len() - 1);
		end
	endtask

	task automatic send_source(ref logic [7:0] s[$]);
		foreach (s[i]) begin
			send_byte(s[i], i == s.size() - 1);
		end
	endtask

	task automatic drain();
		byte_ch.valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
	endtask

	function automatic logic [7:0] sym_char(bit lead);
		int r;
		r = $urandom_range(0, lead ? 56 : 66);
		if (r < 26) return CHAR_UP_A + 8'(r);
		if (r < 52) return CHAR_LO_A + 8'(r - 26);
		if (r < 57) return EXTRA[r - 52];
		return CHAR_ZERO + 8'(r - 57);
	endfunction

	initial begin
		int stall;
		tok_ch.ready <= 1'b0;
		@(posedge arst_n);
		@(posedge clk);
		forever begin
			stall = calm ? 0 : $urandom_range(0, 8);
			if (stall > 0) begin
				tok_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			tok_ch.ready <= 1'b1;
			@(posedge clk);
			while (!tok_ch.valid) @(posedge clk);
		end
	end

	initial begin
		byte_ch.valid <= 1'b0;
		byte_ch.char_in <= 8'd0;
		byte_ch.final_byte <= 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_text("(Az_+-*/9)", 1'b0);
		for (int i = 0; i < 5; i++) send_byte(CHAR_TAB + 8'(i), 1'b0);
		send_text("0 42(", 1'b1);
		send_byte(8'h00, 1'b0);
		send_text("x", 1'b0);
		send_byte(8'h80, 1'b1);
		send_byte(8'hFF, 1'b1);
		send_text("q", 1'b1);
		drain();

		sent = 0;
		while (sent < 145) begin
			src.delete();
			calm = ($urandom_range(0, 3) == 0);
			repeat ($urandom_range(1, 8)) begin
				case ($urandom_range(0, 15))
					0, 1, 2: src.push_back(CHAR_LPAREN);
					3, 4, 5: src.push_back(CHAR_RPAREN);
					6, 7, 8, 9, 10: begin
						n = ($urandom_range(0, 4) == 0) ? $urandom_range(10, 13)
							: $urandom_range(1, 4);
						repeat (n) src.push_back(CHAR_ZERO + 8'($urandom_range(0, 9)));
					end
					11, 12, 13, 14: begin
						src.push_back(sym_char(1'b1));
						repeat ($urandom_range(0, 5)) src.push_back(sym_char(1'b0));
					end
					default: src.push_back(8'($urandom_range(0, 255)));
				endcase
				repeat ($urandom_range(0, 2)) begin
					ws = $urandom_range(0, 5);
					src.push_back(ws == 5 ? CHAR_SPACE : CHAR_TAB + 8'(ws));
				end
			end
			if ($urandom_range(0, 7) == 0) drain();
			send_source(src);
			sent += src.size();
		end
		drain();

		repeat (20) @(posedge clk);
		if (mismatches == 0 && outstanding == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule

[files.f]
hw/rtl/sxtok_pkg.sv
hw/rtl/sxtok_if.sv
hw/rtl/sxtok_scan.sv
hw/rtl/sexpr_token_scanner.sv
sim/sxtok_token_checker.sv
sim/tb.sv
